// ===== rtl/fbc_pkg.sv =====
// Shared types, constants and helpers of the FASTA block compactor.
package fbc_pkg;

	localparam int ADDR_BITS = 32;
	localparam int LEN_BITS = 16;
	localparam int MINLEN_BITS = 16;
	localparam int CMP_BITS = (LEN_BITS > MINLEN_BITS) ? LEN_BITS : MINLEN_BITS;

	localparam logic [7:0] CH_HEADER = 8'h3E;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_STAR = 8'h2A;

	localparam logic [1:0] CFG_BASE_ADDR = 2'd0;
	localparam logic [1:0] CFG_MIN_LEN = 2'd1;

	localparam logic [ADDR_BITS-1:0] ADDR_ONE = ADDR_BITS'(1);
	localparam logic [ADDR_BITS-1:0] ADDR_TWO = ADDR_BITS'(2);
	localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

	typedef struct packed {
		logic [ADDR_BITS-1:0] write_ptr;
		logic [ADDR_BITS-1:0] head_start;
		logic [ADDR_BITS-1:0] body_start;
		logic [LEN_BITS-1:0] body_len;
		logic in_header;
		logic in_body;
		logic newline_pending;
		logic record_open;
		logic [31:0] kept_count;
	} fbc_state_t;

	typedef struct packed {
		logic [31:0] wr_addr;
		logic [7:0] wr_byte;
		logic rec_valid;
		logic [31:0] rec_head_addr;
		logic [31:0] rec_body_addr;
		logic done_res;
		logic [31:0] end_addr;
		logic [31:0] kept_total;
	} fbc_result_t;

	function automatic logic [31:0] addr_out(input logic [ADDR_BITS-1:0] a);
		logic [63:0] t;
		t = 64'(a);
		return t[31:0];
	endfunction

	function automatic logic [ADDR_BITS-1:0] addr_in(input logic [31:0] v);
		logic [63:0] t;
		t = 64'(v);
		return t[ADDR_BITS-1:0];
	endfunction

endpackage

// ===== rtl/fbc_step.sv =====
// Per-byte next-state and result logic of the FASTA block compactor.
module fbc_step (
	input  fbc_pkg::fbc_state_t  cur,
	input  logic [7:0]           byte_in,
	input  logic                 last,
	input  logic [15:0]          min_len,
	output fbc_pkg::fbc_state_t  nxt,
	output fbc_pkg::fbc_result_t res
);
	import fbc_pkg::*;

	logic [ADDR_BITS-1:0] addr;
	logic [ADDR_BITS-1:0] wp_end;
	logic [ADDR_BITS-1:0] end_a;
	logic advance;
	logic opened_now;
	logic long_enough;
	logic end_long;
	logic is_head;
	logic is_nl;
	logic is_star;

	assign is_head = (byte_in == CH_HEADER);
	assign is_nl = (byte_in == CH_NEWLINE);
	assign is_star = (byte_in == CH_STAR);
	assign long_enough = CMP_BITS'(cur.body_len) >= CMP_BITS'(min_len);

	always_comb begin
		nxt = cur;
		res = '0;
		advance = 1'b1;
		opened_now = 1'b0;
		end_a = '0;
		res.wr_byte = byte_in;

		if (cur.newline_pending) begin
			nxt.newline_pending = 1'b0;
			if (is_head) begin
				nxt.write_ptr = cur.write_ptr + ADDR_ONE;
			end
		end

		if (is_head) begin
			if (cur.record_open) begin
				if (!cur.in_body) begin
					nxt.body_start = nxt.write_ptr;
				end
				if (long_enough) begin
					res.rec_valid = 1'b1;
					res.rec_head_addr = addr_out(cur.head_start);
					res.rec_body_addr = addr_out(nxt.body_start);
					nxt.kept_count = cur.kept_count + 32'd1;
				end else begin
					nxt.write_ptr = cur.head_start;
				end
			end
			nxt.head_start = nxt.write_ptr;
			nxt.in_header = 1'b1;
			nxt.in_body = 1'b0;
			nxt.body_len = '0;
			nxt.record_open = 1'b1;
			opened_now = 1'b1;
		end
		addr = nxt.write_ptr;

		if (is_nl) begin
			if (cur.in_header) begin
				if (!last) begin
					nxt.body_start = addr + ADDR_ONE;
					nxt.in_header = 1'b0;
					nxt.in_body = 1'b1;
				end
			end else if (cur.in_body && !last) begin
				nxt.newline_pending = 1'b1;
				advance = 1'b0;
			end
		end else if (is_star) begin
			if (cur.in_body) begin
				advance = 1'b0;
			end
		end else if (!is_head) begin
			if (cur.in_body && cur.body_len != LEN_MAX) begin
				nxt.body_len = cur.body_len + LEN_BITS'(1);
			end
		end

		wp_end = advance ? addr + ADDR_ONE : addr;
		nxt.write_ptr = wp_end;
		end_long = CMP_BITS'(nxt.body_len) >= CMP_BITS'(min_len);

		if (last) begin
			res.done_res = 1'b1;
			if (nxt.record_open) begin
				if (!opened_now && end_long) begin
					res.rec_valid = 1'b1;
					res.rec_head_addr = addr_out(nxt.head_start);
					res.rec_body_addr = addr_out(nxt.in_body ? nxt.body_start : wp_end);
					nxt.kept_count = nxt.kept_count + 32'd1;
					end_a = wp_end - ADDR_ONE;
				end else begin
					end_a = nxt.head_start - ADDR_TWO;
				end
			end else begin
				end_a = wp_end - ADDR_ONE;
			end
			res.end_addr = addr_out(end_a);
			res.kept_total = nxt.kept_count;
		end

		res.wr_addr = addr_out(addr);
	end

endmodule

// ===== rtl/fasta_block_compactor_core.sv =====
// Top level of the FASTA block compactor: input register, state and result register.
// Results: an accepted item waits in the input register, then its result is registered into the result register.
// Throughput: one item per cycle unless res_stall holds a waiting result, set by the combinational update in fbc_step.
// The input register takes a new item while a result waits whenever it can move on.
// Reset: arst_n clears valid flags, block state and registers (base_addr 0, min_len 17).
// After the final byte of a block the state returns to its start and write_ptr to base_addr.
module fasta_block_compactor_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic [7:0]  byte_in,
	input  logic        last,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [31:0] wr_addr,
	output logic [7:0]  wr_byte,
	output logic        rec_valid,
	output logic [31:0] rec_head_addr,
	output logic [31:0] rec_body_addr,
	output logic        done_res,
	output logic [31:0] end_addr,
	output logic [31:0] kept_total,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	import fbc_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        valid_s2;
	fbc_result_t res_s2;
	fbc_state_t  state_q;
	fbc_state_t  state_next;
	fbc_state_t  state_init;
	fbc_result_t res_next;
	logic        busy_q;
	logic [31:0] base_q;
	logic [15:0] min_len_q;
	logic        adv_s1;
	logic        take_in;

	assign adv_s1 = valid_s1 && (!valid_s2 || !res_stall);
	assign item_stall = valid_s1 && !adv_s1;
	assign take_in = item_valid && !item_stall;

	always_comb begin
		state_init = '0;
		state_init.write_ptr = addr_in(base_q);
	end

	fbc_step u_step (
		.cur     (state_q),
		.byte_in (byte_s1),
		.last    (last_s1),
		.min_len (min_len_q),
		.nxt     (state_next),
		.res     (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			byte_s1 <= byte_in;
			last_s1 <= last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s1) begin
			valid_s2 <= 1'b1;
		end else if (!res_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
			busy_q <= 1'b0;
			base_q <= '0;
			min_len_q <= 16'd17;
		end else begin
			if (adv_s1) begin
				state_q <= last_s1 ? state_init : state_next;
				busy_q <= !last_s1;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_BASE_ADDR: begin
						base_q <= cfg_data;
						if (!busy_q && !adv_s1) begin
							state_q.write_ptr <= addr_in(cfg_data);
						end
					end
					CFG_MIN_LEN: min_len_q <= cfg_data[15:0];
					default: ;
				endcase
			end
		end
	end

	assign res_valid = valid_s2;
	assign wr_addr = res_s2.wr_addr;
	assign wr_byte = res_s2.wr_byte;
	assign rec_valid = res_s2.rec_valid;
	assign rec_head_addr = res_s2.rec_head_addr;
	assign rec_body_addr = res_s2.rec_body_addr;
	assign done_res = res_s2.done_res;
	assign end_addr = res_s2.end_addr;
	assign kept_total = res_s2.kept_total;

`ifndef SYNTHESIS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (valid_s1 && valid_s2 && res_stall))
		else $error("input stalled while the result side can move");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !res_stall && !valid_s1) |=> !valid_s2)
		else $error("result item repeated");

	a_block_end: assert property (@(posedge clk) disable iff (!arst_n)
		(adv_s1 && last_s1) |=> (!busy_q && state_q.kept_count == 32'd0
			&& !state_q.record_open))
		else $error("block state not cleared after the final item");

	a_rec_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !res_s2.rec_valid) |-> (res_s2.rec_head_addr == 32'd0
			&& res_s2.rec_body_addr == 32'd0))
		else $error("record addresses set without a confirmed record");
`endif

endmodule

// ===== tb/fasta_block_compactor_core_test.sv =====
// Self-checking testbench of the FASTA block compactor core with a predicting scoreboard.
module fasta_block_compactor_core_test;
	import fbc_pkg::*;

	localparam logic [1:0] CFG_UNUSED_A = 2'd2;
	localparam logic [1:0] CFG_UNUSED_B = 2'd3;
	localparam int RANDOM_ITEMS = 800;
	localparam int HOLD_CYCLES = 120;
	localparam int QUIET_LIMIT = 3000;

	class compactor_scoreboard;
		logic [31:0] base_reg;
		logic [15:0] min_len_reg;
		logic [ADDR_BITS-1:0] wptr;
		logic [ADDR_BITS-1:0] head_start;
		logic [ADDR_BITS-1:0] body_start;
		logic [LEN_BITS-1:0] body_len;
		logic [31:0] kept;
		bit in_header;
		bit in_body;
		bit nl_pending;
		bit rec_open;
		bit busy;
		fbc_result_t pending_writes[$];
		int errors;

		function new();
			errors = 0;
			base_reg = '0;
			min_len_reg = 16'd17;
			restart_block();
		endfunction

		function void restart_block();
			wptr = base_reg;
			head_start = '0;
			body_start = '0;
			body_len = '0;
			kept = '0;
			in_header = 1'b0;
			in_body = 1'b0;
			nl_pending = 1'b0;
			rec_open = 1'b0;
			busy = 1'b0;
		endfunction

		function void write_reg(input logic [1:0] idx, input logic [31:0] val);
			if (idx == CFG_BASE_ADDR) begin
				base_reg = val;
				if (!busy)
					wptr = val;
			end else if (idx == CFG_MIN_LEN) begin
				min_len_reg = val[15:0];
			end
		endfunction

		function fbc_result_t compact_byte(input logic [7:0] b, input logic lst);
			fbc_result_t r;
			logic [ADDR_BITS-1:0] a;
			logic [ADDR_BITS-1:0] t;
			bit adv;
			bit opened;
			r = '0;
			adv = 1'b1;
			opened = 1'b0;
			busy = 1'b1;
			if (nl_pending) begin
				nl_pending = 1'b0;
				if (b == CH_HEADER)
					wptr = wptr + 1;
			end
			if (b == CH_HEADER) begin
				if (rec_open) begin
					if (!in_body)
						body_start = wptr;
					if (body_len >= min_len_reg) begin
						r.rec_valid = 1'b1;
						r.rec_head_addr = 32'(head_start);
						r.rec_body_addr = 32'(body_start);
						kept = kept + 1;
					end else begin
						wptr = head_start;
					end
				end
				head_start = wptr;
				in_header = 1'b1;
				in_body = 1'b0;
				body_len = '0;
				rec_open = 1'b1;
				opened = 1'b1;
			end
			a = wptr;
			if (b == CH_NEWLINE) begin
				if (in_header) begin
					if (!lst) begin
						body_start = a + 1;
						in_header = 1'b0;
						in_body = 1'b1;
					end
				end else if (in_body && !lst) begin
					nl_pending = 1'b1;
					adv = 1'b0;
				end
			end else if (b == CH_STAR) begin
				if (in_body)
					adv = 1'b0;
			end else if (b != CH_HEADER) begin
				if (in_body && body_len != LEN_MAX)
					body_len = body_len + LEN_BITS'(1);
			end
			if (adv)
				wptr = a + 1;
			if (lst) begin
				r.done_res = 1'b1;
				if (rec_open) begin
					if (!opened && body_len >= min_len_reg) begin
						if (!in_body)
							body_start = wptr;
						r.rec_valid = 1'b1;
						r.rec_head_addr = 32'(head_start);
						r.rec_body_addr = 32'(body_start);
						kept = kept + 1;
						t = wptr - 1;
					end else begin
						t = head_start - 2;
					end
				end else begin
					t = wptr - 1;
				end
				r.end_addr = 32'(t);
				r.kept_total = kept;
			end
			r.wr_addr = 32'(a);
			r.wr_byte = b;
			if (lst)
				restart_block();
			return r;
		endfunction

		function void note_item(input logic [7:0] b, input logic lst);
			pending_writes.insert(pending_writes.size(), compact_byte(b, lst));
		endfunction

		function void cmp_field(input string name, input logic [31:0] exp_v,
				input logic [31:0] act_v);
			if (exp_v !== act_v) begin
				$error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
				errors++;
			end
		endfunction

		function void check_result(input fbc_result_t got);
			fbc_result_t e;
			if (pending_writes.size() == 0) begin
				$error("result with no expected item: wr_addr %0h", got.wr_addr);
				errors++;
				return;
			end
			e = pending_writes.pop_front();
			cmp_field("wr_addr", e.wr_addr, got.wr_addr);
			cmp_field("wr_byte", 32'(e.wr_byte), 32'(got.wr_byte));
			cmp_field("rec_valid", 32'(e.rec_valid), 32'(got.rec_valid));
			cmp_field("rec_head_addr", e.rec_head_addr, got.rec_head_addr);
			cmp_field("rec_body_addr", e.rec_body_addr, got.rec_body_addr);
			cmp_field("done_res", 32'(e.done_res), 32'(got.done_res));
			cmp_field("end_addr", e.end_addr, got.end_addr);
			cmp_field("kept_total", e.kept_total, got.kept_total);
		endfunction

		function int pending();
			return pending_writes.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic item_valid;
	logic item_stall;
	logic [7:0] byte_in;
	logic last;
	logic res_valid;
	logic res_stall;
	logic [31:0] wr_addr;
	logic [7:0] wr_byte;
	logic rec_valid;
	logic [31:0] rec_head_addr;
	logic [31:0] rec_body_addr;
	logic done_res;
	logic [31:0] end_addr;
	logic [31:0] kept_total;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [31:0] cfg_data;

	compactor_scoreboard sb;
	fbc_result_t seen;
	bit calm;
	bit hold_req;
	int sent;
	int quiet;

	fasta_block_compactor_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.byte_in(byte_in),
		.last(last),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.wr_addr(wr_addr),
		.wr_byte(wr_byte),
		.rec_valid(rec_valid),
		.rec_head_addr(rec_head_addr),
		.rec_body_addr(rec_body_addr),
		.done_res(done_res),
		.end_addr(end_addr),
		.kept_total(kept_total),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic bit idle_now();
		return !calm && ($urandom_range(0, 99) < 14);
	endfunction

	initial begin
		res_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				res_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			res_stall <= idle_now();
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && !item_stall)
				sb.note_item(byte_in, last);
			if (res_valid && !res_stall) begin
				seen.wr_addr = wr_addr;
				seen.wr_byte = wr_byte;
				seen.rec_valid = rec_valid;
				seen.rec_head_addr = rec_head_addr;
				seen.rec_body_addr = rec_body_addr;
				seen.done_res = done_res;
				seen.end_addr = end_addr;
				seen.kept_total = kept_total;
				sb.check_result(seen);
			end
		end
	end

	initial begin
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((item_valid && !item_stall) || (res_valid && !res_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	task automatic send_item(input logic [7:0] b, input logic l);
		while (idle_now()) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		byte_in <= b;
		last <= l;
		sent++;
		@(posedge clk);
		while (item_stall) @(posedge clk);
	endtask

	task automatic send_text(input string s, input bit closed);
		for (int i = 0; i < s.len(); i++)
			send_item(s[i], closed && (i == s.len() - 1));
	endtask

	task automatic send_block(input bit closed);
		logic [7:0] blk[$];
		string nt = "ACGT";
		int r;
		if ($urandom_range(0, 99) < 15) begin
			repeat ($urandom_range(1, 30))
				blk.insert(blk.size(), 8'($urandom_range(0, 255)));
		end else begin
			if ($urandom_range(0, 9) == 0)
				blk.insert(blk.size(), nt[$urandom_range(0, 3)]);
			repeat ($urandom_range(0, 4)) begin
				blk.insert(blk.size(), CH_HEADER);
				repeat ($urandom_range(0, 5))
					blk.insert(blk.size(), ($urandom_range(0, 9) == 0) ? CH_STAR :
						8'($urandom_range(97, 122)));
				if ($urandom_range(0, 9) != 0)
					blk.insert(blk.size(), CH_NEWLINE);
				repeat ($urandom_range(0, 24)) begin
					r = $urandom_range(0, 99);
					if (r < 80)
						blk.insert(blk.size(), nt[$urandom_range(0, 3)]);
					else if (r < 88)
						blk.insert(blk.size(), CH_NEWLINE);
					else if (r < 94)
						blk.insert(blk.size(), CH_STAR);
					else
						blk.insert(blk.size(), 8'($urandom_range(0, 255)));
				end
				if ($urandom_range(0, 1) != 0)
					blk.insert(blk.size(), CH_NEWLINE);
			end
			if (blk.size() == 0)
				blk.insert(blk.size(), nt[$urandom_range(0, 3)]);
		end
		foreach (blk[i])
			send_item(blk[i], closed && (i == blk.size() - 1));
	endtask

	task automatic cfg_pulse(input logic [1:0] idx, input logic [31:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		sb.write_reg(idx, val);
	endtask

	task automatic set_regs(input logic [31:0] base, input logic [31:0] mlen, input bit junk);
		if (junk)
			cfg_pulse(($urandom_range(0, 1) != 0) ? CFG_UNUSED_A : CFG_UNUSED_B, $urandom);
		cfg_pulse(CFG_BASE_ADDR, base);
		cfg_pulse(CFG_MIN_LEN, mlen);
		cfg_we <= 1'b0;
	endtask

	task automatic finish_phase();
		item_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	initial begin
		int phase;
		int rand_start;
		logic [31:0] base_v;
		logic [31:0] mlen_v;
		arst_n = 1'b0;
		item_valid = 1'b0;
		byte_in = '0;
		last = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_BASE_ADDR;
		cfg_data = '0;
		calm = 1'b0;
		hold_req = 1'b0;
		sent = 0;
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Defaults after reset, then a wrapping base and a short minimum length.
		send_text(">d\nACGT\n", 1);
		finish_phase();
		cfg_pulse(CFG_UNUSED_A, $urandom);
		cfg_pulse(CFG_UNUSED_B, $urandom);
		set_regs(32'hFFFF_FFFE, 32'd2, 1'b0);
		send_text("A*>h*\nAC*\n", 1'b0);
		send_item(8'h00, 1'b0);
		send_item(8'hFF, 1'b0);
		send_text("\n>>q\nT>\nAC\n", 1'b1);
		finish_phase();

		set_regs(32'h0, 32'h0, 1'b0);
		send_text(">\n", 1'b1);
		send_text(">ab", 1'b1);
		send_text(">x>y\nA", 1'b1);
		send_text("X>", 1'b1);
		send_text("Z", 1'b1);
		finish_phase();

		rand_start = sent;
		phase = 0;
		while (sent - rand_start < RANDOM_ITEMS) begin
			case ($urandom_range(0, 3))
				0: base_v = 32'h0;
				1: base_v = 32'hFFFF_FFFF;
				2: base_v = 32'hFFFF_FFF8;
				default: base_v = $urandom;
			endcase
			mlen_v = (phase == 4) ? $urandom : 32'($urandom_range(0, 12));
			set_regs(base_v, mlen_v, $urandom_range(0, 3) == 0);
			calm = (phase == 2) || (phase == 3);
			if (phase == 1)
				hold_req = 1'b1;
			repeat ($urandom_range(3, 6)) send_block(1'b1);
			if ($urandom_range(0, 3) == 0)
				send_block(1'b0);
			finish_phase();
			phase++;
		end
		calm = 1'b0;

		repeat (8) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule

// ===== fasta_block_compactor_core.f =====
rtl/fbc_pkg.sv
rtl/fbc_step.sv
rtl/fasta_block_compactor_core.sv
tb/fasta_block_compactor_core_test.sv
